FILE: rtl/ckep_pkg.sv
// Shared types, constants and constant functions of the CORDIC Kepler solver.
`default_nettype none

package ckep_pkg;

   // Fixed-point formats.
   localparam int FRACTION_BITS = 29;
   localparam int NUM_CELLS     = 57;
   localparam int DOUBLED       = 27;
   localparam int IN_W          = 32;
   localparam int VAL_W         = 33;
   localparam int DIFF_W        = 35;
   localparam int ECC_W         = 30;
   localparam int COUNT_W       = 6;
   localparam int SHIFT_W       = 6;
   localparam int PROD_W        = 61;
   localparam int ANOM_W        = 32;
   localparam int TRIG_W        = 31;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   // Inverse gain of the rotation sequence, rounded to 32 fraction bits.
   localparam logic [63:0] K_MANTISSA = 64'h001799b34c7fac93;
   localparam logic [63:0] K32_WIDE   = (K_MANTISSA + (64'd1 << 21)) >> 22;
   localparam logic [30:0] K32        = K32_WIDE[30:0];

   // Register index codes (address bit 2).
   localparam logic REG_ECCENTRICITY = 1'b0;
   localparam logic REG_ITER_COUNT   = 1'b1;

   // One item traveling down the cell chain.
   typedef struct packed {
      logic                    valid;
      logic signed [IN_W-1:0]  m;
      logic signed [VAL_W-1:0] e;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] s;
   } ckep_vec_type;

   // 53-bit significands of atan(2^-k); value = sig * 2^-(53+k).
   function automatic logic [63:0] atan_sig(input logic [SHIFT_W-1:0] k);
      logic [63:0] r;
      case (k)
         6'd0:    r = 64'h001921fb54442d18;
         6'd1:    r = 64'h001dac670561bb4f;
         6'd2:    r = 64'h001f5b75f92c80dd;
         6'd3:    r = 64'h001fd5ba9aac2f6e;
         6'd4:    r = 64'h001ff55bb72cfdea;
         6'd5:    r = 64'h001ffd55bba97625;
         6'd6:    r = 64'h001fff555bbb729b;
         6'd7:    r = 64'h001fffd555bbba97;
         6'd8:    r = 64'h001ffff5555bbbb7;
         6'd9:    r = 64'h001ffffd5555bbbc;
         6'd10:   r = 64'h001fffff55555bbc;
         6'd11:   r = 64'h001fffffd55555bc;
         6'd12:   r = 64'h001ffffff555555c;
         6'd13:   r = 64'h001ffffffd555556;
         6'd14:   r = 64'h001fffffff555555;
         6'd15:   r = 64'h001fffffffd55555;
         6'd16:   r = 64'h001ffffffff55555;
         6'd17:   r = 64'h001ffffffffd5555;
         6'd18:   r = 64'h001fffffffff5555;
         6'd19:   r = 64'h001fffffffffd555;
         6'd20:   r = 64'h001ffffffffff555;
         6'd21:   r = 64'h001ffffffffffd55;
         6'd22:   r = 64'h001fffffffffff55;
         6'd23:   r = 64'h001fffffffffffd5;
         6'd24:   r = 64'h001ffffffffffff5;
         6'd25:   r = 64'h001ffffffffffffd;
         6'd26:   r = 64'h001fffffffffffff;
         // Beyond the table atan(2^-k) equals 2^-k at this precision.
         default: r = 64'd1 << 53;
      endcase
      return r;
   endfunction

   // Shift of iteration n: each shift twice below DOUBLED, then once.
   function automatic logic [SHIFT_W-1:0] shift_of(input int n);
      int k;
      k = (n < 2 * DOUBLED) ? (n >> 1) : (n - DOUBLED);
      return SHIFT_W'(k);
   endfunction

   // atan(2^-k) rounded to FRACTION_BITS fraction bits, ties up.
   function automatic logic [VAL_W-1:0] atan_fixed(input logic [SHIFT_W-1:0] k);
      logic [63:0] m;
      logic [63:0] r;
      int          s;
      m = atan_sig(k);
      s = 53 + int'(k) - FRACTION_BITS;
      if (s <= 0) begin
         r = m << (-s);
      end else if (s >= 64) begin
         r = 64'd0;
      end else begin
         r = (m >> s) + ((m >> (s - 1)) & 64'd1);
      end
      return r[VAL_W-1:0];
   endfunction

   // Clamp a chain value to the eccentric anomaly field.
   function automatic logic [ANOM_W-1:0] sat_anom(input logic signed [VAL_W-1:0] v);
      logic [ANOM_W-1:0] r;
      if (v[VAL_W-1] != v[ANOM_W-1]) begin
         r = v[VAL_W-1] ? {1'b1, {(ANOM_W-1){1'b0}}} : {1'b0, {(ANOM_W-1){1'b1}}};
      end else begin
         r = v[ANOM_W-1:0];
      end
      return r;
   endfunction

   // Clamp a chain value to the e*cos / e*sin field.
   function automatic logic [TRIG_W-1:0] sat_trig(input logic signed [VAL_W-1:0] v);
      logic [TRIG_W-1:0] r;
      if ((v[VAL_W-1] != v[TRIG_W-1]) || (v[VAL_W-2] != v[TRIG_W-1])) begin
         r = v[VAL_W-1] ? {1'b1, {(TRIG_W-1){1'b0}}} : {1'b0, {(TRIG_W-1){1'b1}}};
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ckep_seed.sv
// Seed stages: scale the rotation gain by the eccentricity and form the start vector.
`default_nettype none

module ckep_seed (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    advance,
   input  wire                                    in_valid,
   input  wire  [ckep_pkg::IN_W-1:0]              in_m,
   input  wire  [ckep_pkg::ECC_W-1:0]             ecc,
   output ckep_pkg::ckep_vec_type                 seed_out
);

   logic                                 s1_valid_ff;
   logic signed [ckep_pkg::IN_W-1:0]     s1_m_ff;
   logic [ckep_pkg::PROD_W-1:0]          s1_prod_ff;
   logic [ckep_pkg::PROD_W-1:0]          s1_prod_in;
   logic [ckep_pkg::PROD_W:0]            rounded;
   logic signed [ckep_pkg::VAL_W-1:0]    c0;
   ckep_pkg::ckep_vec_type               s2_ff;
   ckep_pkg::ckep_vec_type               s2_in;

   // Gain times eccentricity; the product is registered before rounding.
   assign s1_prod_in = ckep_pkg::PROD_W'(ckep_pkg::K32) * ckep_pkg::PROD_W'(ecc);

   // Round to nearest, ties up, at 32 fraction bits of the gain.
   assign rounded = {1'b0, s1_prod_ff} + ((ckep_pkg::PROD_W + 1)'(1) << 31);
   assign c0      = ckep_pkg::VAL_W'(rounded[ckep_pkg::PROD_W:32]);

   always_comb begin
      s2_in.valid = s1_valid_ff;
      s2_in.m     = s1_m_ff;
      s2_in.e     = '0;
      s2_in.c     = c0;
      s2_in.s     = '0;
   end

   // Both seed stages; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_ff.valid <= s2_in.valid;
      end
      if (advance) begin
         s1_m_ff    <= in_m;
         s1_prod_ff <= s1_prod_in;
         s2_ff.m    <= s2_in.m;
         s2_ff.e    <= s2_in.e;
         s2_ff.c    <= s2_in.c;
         s2_ff.s    <= s2_in.s;
      end
   end

   assign seed_out = s2_ff;

endmodule

`default_nettype wire

FILE: rtl/ckep_cell.sv
// One rotation cell: a single CORDIC iteration with its own stage register.
`default_nettype none

module ckep_cell (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    advance,
   input  wire                                    active,
   input  wire  [ckep_pkg::SHIFT_W-1:0]           shift,
   input  wire  [ckep_pkg::VAL_W-1:0]             atan,
   input  wire  ckep_pkg::ckep_vec_type           stage_in,
   output ckep_pkg::ckep_vec_type                 stage_out
);

   logic signed [ckep_pkg::VAL_W-1:0]  e_cur;
   logic signed [ckep_pkg::VAL_W-1:0]  c_cur;
   logic signed [ckep_pkg::VAL_W-1:0]  s_cur;
   logic signed [ckep_pkg::VAL_W-1:0]  a_val;
   logic signed [ckep_pkg::VAL_W-1:0]  dc;
   logic signed [ckep_pkg::VAL_W-1:0]  ds;
   logic signed [ckep_pkg::DIFF_W-1:0] diff;
   logic                               go_down;
   ckep_pkg::ckep_vec_type             stage_ff;
   ckep_pkg::ckep_vec_type             stage_in_next;

   assign e_cur = stage_in.e;
   assign c_cur = stage_in.c;
   assign s_cur = stage_in.s;
   assign a_val = atan;

   // Arithmetic shifts round toward minus infinity.
   assign dc = s_cur >>> shift;
   assign ds = c_cur >>> shift;

   // Sign of E - e*sinE - M picks the rotation direction; zero counts as non-negative.
   assign diff    = ckep_pkg::DIFF_W'(e_cur) - ckep_pkg::DIFF_W'(s_cur)
                    - ckep_pkg::DIFF_W'(stage_in.m);
   assign go_down = !diff[ckep_pkg::DIFF_W-1];

   // Rotate when this iteration is enabled, else pass the vector on unchanged.
   always_comb begin
      stage_in_next = stage_in;
      if (active) begin
         if (go_down) begin
            stage_in_next.e = e_cur - a_val;
            stage_in_next.c = c_cur + dc;
            stage_in_next.s = s_cur - ds;
         end else begin
            stage_in_next.e = e_cur + a_val;
            stage_in_next.c = c_cur - dc;
            stage_in_next.s = s_cur + ds;
         end
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_next.valid;
      end
      if (advance) begin
         stage_ff.m <= stage_in_next.m;
         stage_ff.e <= stage_in_next.e;
         stage_ff.c <= stage_in_next.c;
         stage_ff.s <= stage_in_next.s;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

FILE: rtl/cordic_kepler_solver.sv
// Path from an accepted request transaction to its response: two seed stages,
// a chain of 57 rotation cells and the output register.
// Throughput: one transaction per cycle; the whole chain stalls together while a
// response waits, so one item enters for every result taken.
// Reset clears every stage valid and sets eccentricity to 0 and the iteration count to 57.
`default_nettype none

module cordic_kepler_solver (
   input  wire         clock,
   input  wire         reset,
   // Request: [31:0] mean_anomaly
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,
   // Response: [31:0] ecc_anomaly, [62:32] ecc_times_cos, [93:63] ecc_times_sin
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,
   // Register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int N = ckep_pkg::NUM_CELLS;

   logic [ckep_pkg::ECC_W-1:0]   ecc_ff;
   logic [ckep_pkg::ECC_W-1:0]   ecc_in;
   logic [ckep_pkg::COUNT_W-1:0] count_ff;
   logic [ckep_pkg::COUNT_W-1:0] count_in;
   logic                         csr_write;
   logic                         advance;
   logic                         out_valid_ff;
   logic [93:0]                  out_data_ff;
   logic [93:0]                  out_data_in;
   ckep_pkg::ckep_vec_type       chain [0:N];

   // Register port: writes complete in the access phase, reads are direct.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ecc_in   = ecc_ff;
      count_in = count_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            ckep_pkg::REG_ECCENTRICITY: ecc_in   = csr_pwdata[ckep_pkg::ECC_W-1:0];
            ckep_pkg::REG_ITER_COUNT:   count_in = csr_pwdata[ckep_pkg::COUNT_W-1:0];
            default:                    ecc_in   = ecc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecc_ff   <= '0;
         count_ff <= ckep_pkg::COUNT_W'(ckep_pkg::NUM_CELLS);
      end else begin
         ecc_ff   <= ecc_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         ckep_pkg::REG_ECCENTRICITY: csr_prdata = 32'(ecc_ff);
         ckep_pkg::REG_ITER_COUNT:   csr_prdata = 32'(count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // The chain moves whenever the output register is free or being emptied.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   ckep_seed u_seed (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .in_m     (req_tdata),
      .ecc      (ecc_ff),
      .seed_out (chain[0])
   );

   // Rotation cells; cell n runs iteration n when the count exceeds n.
   for (genvar n = 0; n < N; n++) begin : g_cell
      ckep_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .active    (count_ff > ckep_pkg::COUNT_W'(n)),
         .shift     (ckep_pkg::shift_of(n)),
         .atan      (ckep_pkg::atan_fixed(ckep_pkg::shift_of(n))),
         .stage_in  (chain[n]),
         .stage_out (chain[n+1])
      );
   end

   // Output register with saturation to the field ranges.
   assign out_data_in = {ckep_pkg::sat_trig(chain[N].s),
                         ckep_pkg::sat_trig(chain[N].c),
                         ckep_pkg::sat_anom(chain[N].e)};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

   // A waiting response holds the whole chain, so no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while a response is stalled");

   // An accepted request enters the first seed stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> u_seed.s1_valid_ff)
      else $error("accepted request lost at the seed stage");

   // A new response only appears when the last cell held a valid item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(chain[N].valid))
      else $error("response appeared without an item leaving the chain");

endmodule

`default_nettype wire

FILE: test/ckep_checker.sv
// Scoreboard for the CORDIC Kepler solver: tracks registers, predicts responses and compares.
module ckep_checker (
   input  wire         clock,
   input  wire         reset,
   // Request channel, watched only.
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,    // [31:0] mean_anomaly
   // Response channel, watched only.
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [95:0] rsp_tdata,    // [31:0] ecc_anomaly, [62:32] ecc_times_cos,
                                     // [93:63] ecc_times_sin
   // Register port, watched only.
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   input  wire         csr_pready,
   output int          mismatch_count,
   output int          in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] ecc_anomaly;
      logic [30:0] ecc_times_cos;
      logic [30:0] ecc_times_sin;
   } kepler_result_type;

   // Inverse rotation gain with 32 fraction bits, rounded half up from its 53-bit significand.
   localparam logic [63:0] GAIN_Q32    = (64'h001799b34c7fac93 + (64'd1 << 21)) >> 22;
   localparam int          MAX_STEPS   = 57;
   localparam int          TWICE_LIMIT = 27;

   logic [29:0]       ecc_reg;
   logic [5:0]        steps_reg;
   kepler_result_type expected_q[$];

   // The significand holds atan(2^-k) scaled by 2^(53+k); keep 29 fraction bits, half up.
   function automatic longint arctan_q29(input int k);
      logic [63:0] sig;
      int          sh;
      case (k)
         0:       sig = 64'h001921fb54442d18;
         1:       sig = 64'h001dac670561bb4f;
         2:       sig = 64'h001f5b75f92c80dd;
         3:       sig = 64'h001fd5ba9aac2f6e;
         4:       sig = 64'h001ff55bb72cfdea;
         5:       sig = 64'h001ffd55bba97625;
         6:       sig = 64'h001fff555bbb729b;
         7:       sig = 64'h001fffd555bbba97;
         8:       sig = 64'h001ffff5555bbbb7;
         9:       sig = 64'h001ffffd5555bbbc;
         10:      sig = 64'h001fffff55555bbc;
         11:      sig = 64'h001fffffd55555bc;
         12:      sig = 64'h001ffffff555555c;
         13:      sig = 64'h001ffffffd555556;
         14:      sig = 64'h001fffffff555555;
         15:      sig = 64'h001fffffffd55555;
         16:      sig = 64'h001ffffffff55555;
         17:      sig = 64'h001ffffffffd5555;
         18:      sig = 64'h001fffffffff5555;
         19:      sig = 64'h001fffffffffd555;
         20:      sig = 64'h001ffffffffff555;
         21:      sig = 64'h001ffffffffffd55;
         22:      sig = 64'h001fffffffffff55;
         23:      sig = 64'h001fffffffffffd5;
         24:      sig = 64'h001ffffffffffff5;
         25:      sig = 64'h001ffffffffffffd;
         26:      sig = 64'h001fffffffffffff;
         // For larger shifts the arctangent equals the shifted one at this precision.
         default: sig = 64'd1 << 53;
      endcase
      sh = 24 + k;
      return longint'((sig >> sh) + ((sig >> (sh - 1)) & 64'd1));
   endfunction

   // Clamp a wide value to a signed field of the given width.
   function automatic logic [31:0] clamp_field(input longint v, input int bits);
      longint hi_lim;
      longint lo_lim;
      hi_lim = (longint'(1) << (bits - 1)) - 1;
      lo_lim = -hi_lim - 1;
      if (v > hi_lim) v = hi_lim;
      if (v < lo_lim) v = lo_lim;
      return v[31:0];
   endfunction

   // Rotate the seed vector toward the root of M = E - e*sin(E).
   function automatic kepler_result_type solve_kepler(input logic [31:0] m_raw,
                                                      input logic [29:0] ecc,
                                                      input logic [5:0]  steps);
      kepler_result_type r;
      logic [63:0]       prod;
      longint            m, c, s, anom, dc, ds, a;
      int                count, k, n;
      m    = longint'(signed'(m_raw));
      prod = GAIN_Q32 * {34'd0, ecc} + (64'd1 << 31);
      c    = longint'(prod >> 32);
      s    = 0;
      anom = 0;
      count = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
      for (n = 0; n < count; n++) begin
         // Each shift is used twice in the first part of the sequence.
         k  = (n < 2 * TWICE_LIMIT) ? n / 2 : n - TWICE_LIMIT;
         dc = s >>> k;
         ds = c >>> k;
         a  = arctan_q29(k);
         // A residual of exactly zero steps the angle down.
         if (anom - s - m >= 0) begin
            anom -= a;
            c    += dc;
            s    -= ds;
         end else begin
            anom += a;
            c    -= dc;
            s    += ds;
         end
      end
      r.ecc_anomaly   = clamp_field(anom, 32);
      r.ecc_times_cos = 31'(clamp_field(c, 31));
      r.ecc_times_sin = 31'(clamp_field(s, 31));
      return r;
   endfunction

   // Predict on each request, compare on each response, and follow register writes.
   always @(posedge clock) begin
      kepler_result_type want;
      int                bad;
      bad = 0;
      if (reset) begin
         ecc_reg        <= '0;
         steps_reg      <= 6'd57;
         expected_q.delete();
         in_flight      <= 0;
         mismatch_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(solve_kepler(req_tdata, ecc_reg, steps_reg));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("response transaction %h arrived with nothing expected", rsp_tdata);
               bad = 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[31:0] !== want.ecc_anomaly) begin
                  $error("ecc_anomaly: expected %h, got %h", want.ecc_anomaly, rsp_tdata[31:0]);
                  bad++;
               end
               if (rsp_tdata[62:32] !== want.ecc_times_cos) begin
                  $error("ecc_times_cos: expected %h, got %h",
                         want.ecc_times_cos, rsp_tdata[62:32]);
                  bad++;
               end
               if (rsp_tdata[93:63] !== want.ecc_times_sin) begin
                  $error("ecc_times_sin: expected %h, got %h",
                         want.ecc_times_sin, rsp_tdata[93:63]);
                  bad++;
               end
            end
         end
         // Register writes take effect for the following requests.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               ckep_pkg::REG_ECCENTRICITY: ecc_reg   <= csr_pwdata[29:0];
               ckep_pkg::REG_ITER_COUNT:   steps_reg <= csr_pwdata[5:0];
               default: ;
            endcase
         end
         mismatch_count <= mismatch_count + bad;
         in_flight      <= expected_q.size();
      end
   end

endmodule

FILE: test/tb_cordic_kepler_solver.sv
// Testbench top for the CORDIC Kepler solver: clock, reset, stimulus, register setup, verdict.
module tb_cordic_kepler_solver;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] M_LIMIT     = 32'd1686629713;   // pi in Q29
   localparam logic [29:0] ECC_ONE     = 30'h20000000;
   localparam int          DIRECTED    = 20;
   localparam int          HOLD_AT     = DIRECTED + 10;
   localparam int          HOLD_CYCLES = 400;
   localparam int          CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int in_flight;
   int responses_taken = 0;
   int cycle_count     = 0;
   bit sender_fast     = 1'b0;
   bit receiver_fast   = 1'b0;

   // Anomalies for the directed part, all at full eccentricity.
   logic [31:0] probe_m [16] = '{
      32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF,
      32'h80000000, 32'h6487ED51, 32'h9B7812AF, 32'h3243F6A8,
      32'hCDBC0958, 32'h20000000, 32'hE0000000, 32'h55555555,
      32'hAAAAAAAA, 32'h00000100, 32'h0BADF00D, 32'hF0000001
   };

   cordic_kepler_solver dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ckep_checker kepler_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .in_flight      (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one request transaction, keeping valid high when no gap follows.
   task automatic send_anomaly(input logic [31:0] m);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_csr(input logic reg_sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Set both registers once the pipeline has drained; unused upper bits get noise.
   task automatic configure(input logic [29:0] ecc, input logic [5:0] steps);
      while (in_flight != 0) @(negedge clock);
      write_csr(ckep_pkg::REG_ECCENTRICITY, {2'($urandom()), ecc});
      write_csr(ckep_pkg::REG_ITER_COUNT, {26'($urandom()), steps});
   endtask

   // Mostly anomalies within +-pi, sometimes any 32-bit pattern.
   function automatic logic [31:0] rand_anomaly();
      if ($urandom_range(0, 7) == 0) return $urandom();
      return 32'($urandom_range(0, 2 * M_LIMIT)) - M_LIMIT;
   endfunction

   // Mostly eccentricities within 0..1, sometimes the whole register.
   function automatic logic [29:0] rand_ecc();
      if ($urandom_range(0, 4) == 0) return 30'($urandom());
      return 30'($urandom_range(0, ECC_ONE));
   endfunction

   task automatic run_phase(input logic [29:0] ecc, input logic [5:0] steps,
                            input int items, input bit fast);
      configure(ecc, steps);
      sender_fast = fast;
      repeat (items) send_anomaly(rand_anomaly());
      req_tvalid <= 1'b0;
   endtask

   // Response side: random stalls, stretches without stalls, and one long hold-off.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (responses_taken % 50 == 0) receiver_fast = ($urandom_range(0, 3) == 0);
         if (responses_taken == HOLD_AT) stall = HOLD_CYCLES;
         else if (receiver_fast) stall = 0;
         else stall = $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         responses_taken++;
         @(negedge clock);
      end
   end

   // Main sequence.
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: zero eccentricity, full iteration count.
      send_anomaly(32'h00000000);
      send_anomaly(M_LIMIT);
      send_anomaly(-M_LIMIT);
      send_anomaly(32'h80000000);
      req_tvalid <= 1'b0;

      // Directed extremes at eccentricity one.
      configure(ECC_ONE, 6'd57);
      foreach (probe_m[i]) send_anomaly(probe_m[i]);
      req_tvalid <= 1'b0;

      // Back-to-back phase that meets the long response hold-off.
      run_phase(rand_ecc(), 6'd57, 200, 1'b1);
      // Zero eccentricity, a single iteration, saturated and zero iteration counts.
      run_phase(30'd0, 6'd57, 75, 1'b0);
      run_phase(ECC_ONE, 6'd1, 75, 1'b0);
      run_phase(30'h3FFFFFFF, 6'd63, 75, 1'($urandom()));
      run_phase(rand_ecc(), 6'd0, 75, 1'b0);
      run_phase(rand_ecc(), 6'd58, 75, 1'b0);
      repeat (3) run_phase(rand_ecc(), 6'($urandom_range(0, 63)), 75, 1'($urandom()));

      // Drain, then leave room for any stray response.
      while (in_flight != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
